/* rtl/ps2_mouse_packet_tracker_defines.svh */
// Assertion macros shared by the RTL. Define NO_ASSERTIONS to compile them out.
`ifndef PS2_MOUSE_PACKET_TRACKER_DEFINES_SVH
`define PS2_MOUSE_PACKET_TRACKER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked only while out of reset.
`define PS2MPT_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ps2mpt assertion failed");
// Checked at every edge, reset included.
`define PS2MPT_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("ps2mpt assertion failed");
`else
`define PS2MPT_ASSERT(label, prop)
`define PS2MPT_ASSERT_ALWAYS(label, prop)
`endif

`endif

/* rtl/ps2mpt_pkg.sv */
package ps2mpt_pkg;

  // Field and register widths.
  localparam int unsigned POS_W   = 10;
  localparam int unsigned SIZE_W  = 11;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned DELTA_W = BYTE_W + 1;
  localparam int unsigned SUM_W   = POS_W + 2;
  localparam int unsigned OUT_W   = 24;

  // Largest coordinate the position registers can hold.
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // Reset values.
  localparam logic [SIZE_W-1:0] WIDTH_RST  = SIZE_W'(800);
  localparam logic [SIZE_W-1:0] HEIGHT_RST = SIZE_W'(600);
  localparam logic [POS_W-1:0]  POS_X_RST  = POS_W'(400);
  localparam logic [POS_W-1:0]  POS_Y_RST  = POS_W'(300);

  // Bits of the first packet byte.
  localparam int unsigned SYNC_BIT = 3;
  localparam int unsigned LEFT_BIT = 0;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  // Position within the current three-byte packet.
  typedef enum logic [2:0] {
    IDX_FIRST  = 3'b001,
    IDX_SECOND = 3'b010,
    IDX_THIRD  = 3'b100
  } byte_idx_t;

endpackage

/* rtl/ps2_mouse_packet_tracker.sv */
// PS/2 mouse packet tracker.
// Input stream: one controller byte per word, in_tdata holds the byte and
// in_tuser marks it as coming from the mouse channel; other bytes are dropped.
// Mouse bytes build three-byte packets; a packet starts only on a byte whose
// sync bit (bit 3) is set. Each completed packet yields one output word with
// the clamped pointer position, the left button level and a click pulse.
// Configuration: cfg_index 0 writes the screen width, 1 the screen height;
// writes are always taken and belong to idle periods between packets.
// Flow: a word is registered on acceptance and processed once the output slot is
// free; a third byte passes through the input register and then the output
// register that drives out_tvalid, and a waiting result can hold it in between.
// Throughput: one input word per cycle while no result waits on out_tready, set by
// the single input register that feeds the update logic and the single output register.
// Reset: packet position returns to the first byte, pointer to (400, 300),
// button to released, screen size to 800 x 600, and no word is pending.
// Stalls: while a result waits on out_tready, one more input word is held in
// the input register; further input is refused until the result is taken.
`include "ps2_mouse_packet_tracker_defines.svh"

module ps2_mouse_packet_tracker (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input stream.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ps2mpt_pkg::BYTE_W-1:0]   in_tdata,   // [7:0] data_byte
  input  logic                            in_tuser,   // [0] from_aux
  // Result stream.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [9:0] pointer_x, [19:10] pointer_y, [20] button_held, [21] click_event,
  // [23:22] zero
  output logic [ps2mpt_pkg::OUT_W-1:0]    out_tdata,
  // Configuration write channel.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_index,
  input  logic [ps2mpt_pkg::SIZE_W-1:0]   cfg_data
);
  import ps2mpt_pkg::*;

  // Input register.
  logic              in_v_r, in_v_nxt;
  logic [BYTE_W-1:0] in_byte_r;
  logic              in_aux_r;

  // Tracker state.
  byte_idx_t         idx_r, idx_nxt;
  logic              pkt_btn_r, pkt_btn_nxt;
  logic [BYTE_W-1:0] pkt_dx_r, pkt_dx_nxt;
  logic [POS_W-1:0]  pos_x_r, pos_x_nxt;
  logic [POS_W-1:0]  pos_y_r, pos_y_nxt;
  logic              held_r, held_nxt;
  logic              click_r, click_nxt;
  logic              out_v_r, out_v_nxt;
  logic [SIZE_W-1:0] width_r, width_nxt;
  logic [SIZE_W-1:0] height_r, height_nxt;

  logic                      adv;
  logic                      done;
  logic signed [DELTA_W-1:0] dx;
  logic signed [DELTA_W-1:0] dy;
  logic [POS_W-1:0]          x_moved;
  logic [POS_W-1:0]          y_moved;

  // Handshakes: the input register moves on when the output slot is free.
  assign adv       = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || adv;
  assign cfg_ready = 1'b1;

  // Deltas: X is added, Y is subtracted.
  assign dx = $signed({pkt_dx_r[BYTE_W-1], pkt_dx_r});
  assign dy = DELTA_W'(0) - $signed({in_byte_r[BYTE_W-1], in_byte_r});

  ps2mpt_move u_move_x (
    .pos     (pos_x_r),
    .delta   (dx),
    .size    (width_r),
    .pos_new (x_moved)
  );

  ps2mpt_move u_move_y (
    .pos     (pos_y_r),
    .delta   (dy),
    .size    (height_r),
    .pos_new (y_moved)
  );

  // Packet assembly and position update.
  always_comb begin
    idx_nxt     = idx_r;
    pkt_btn_nxt = pkt_btn_r;
    pkt_dx_nxt  = pkt_dx_r;
    pos_x_nxt   = pos_x_r;
    pos_y_nxt   = pos_y_r;
    held_nxt    = held_r;
    click_nxt   = click_r;
    done        = 1'b0;
    if (adv && in_aux_r) begin
      unique case (idx_r)
        IDX_SECOND: begin
          pkt_dx_nxt = in_byte_r;
          idx_nxt    = IDX_THIRD;
        end
        IDX_THIRD: begin
          done      = 1'b1;
          idx_nxt   = IDX_FIRST;
          held_nxt  = pkt_btn_r;
          click_nxt = pkt_btn_r && !held_r;
          pos_x_nxt = x_moved;
          pos_y_nxt = y_moved;
        end
        default: begin
          if (in_byte_r[SYNC_BIT]) begin
            pkt_btn_nxt = in_byte_r[LEFT_BIT];
            idx_nxt     = IDX_SECOND;
          end
        end
      endcase
    end
  end

  // Stream control.
  always_comb begin
    in_v_nxt = in_v_r;
    if (in_tvalid && in_tready) begin
      in_v_nxt = 1'b1;
    end else if (adv) begin
      in_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (done) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  // Configuration writes.
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_WIDTH:  width_nxt  = cfg_data;
        REG_HEIGHT: height_nxt = cfg_data;
        default:    width_nxt  = width_r;
      endcase
    end
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      idx_r    <= IDX_FIRST;
      pos_x_r  <= POS_X_RST;
      pos_y_r  <= POS_Y_RST;
      held_r   <= 1'b0;
      click_r  <= 1'b0;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else begin
      in_v_r   <= in_v_nxt;
      out_v_r  <= out_v_nxt;
      idx_r    <= idx_nxt;
      pos_x_r  <= pos_x_nxt;
      pos_y_r  <= pos_y_nxt;
      held_r   <= held_nxt;
      click_r  <= click_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_aux_r  <= in_tuser;
    end
    pkt_btn_r <= pkt_btn_nxt;
    pkt_dx_r  <= pkt_dx_nxt;
  end

  // Result word.
  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, click_r, held_r, pos_y_r, pos_x_r};

  // Checks.
  `PS2MPT_ASSERT(a_third_byte_gives_word,
    (adv && in_aux_r && idx_r == IDX_THIRD) |=> out_v_r)
  `PS2MPT_ASSERT(a_no_overrun,
    (in_v_r && out_v_r && !out_tready) |-> !in_tready)
  `PS2MPT_ASSERT(a_click_is_press,
    done |=> (click_r == (held_r && !$past(held_r))))
  `PS2MPT_ASSERT_ALWAYS(a_reset_clears,
    !rst_n |=> (!out_v_r && !in_v_r && idx_r == IDX_FIRST))

endmodule

/* rtl/ps2mpt_move.sv */
// Moves one coordinate by a signed delta and clamps it to [0, size-1],
// saturating the upper bound at the largest representable position.
module ps2mpt_move (
  input  logic [ps2mpt_pkg::POS_W-1:0]          pos,
  input  logic signed [ps2mpt_pkg::DELTA_W-1:0] delta,
  input  logic [ps2mpt_pkg::SIZE_W-1:0]         size,
  output logic [ps2mpt_pkg::POS_W-1:0]          pos_new
);
  import ps2mpt_pkg::*;

  logic [SIZE_W-1:0]       size_m1;
  logic [POS_W-1:0]        lim;
  logic signed [SUM_W-1:0] sum;

  // Upper bound: a size of zero behaves as one.
  always_comb begin
    size_m1 = (size == '0) ? '0 : size - SIZE_W'(1);
    if (size_m1 > SIZE_W'(POS_MAX)) begin
      lim = POS_MAX;
    end else begin
      lim = size_m1[POS_W-1:0];
    end
  end

  // Signed sum, wide enough for both overshoots.
  assign sum = $signed({2'b00, pos}) + $signed({{(SUM_W-DELTA_W){delta[DELTA_W-1]}}, delta});

  // Clamp below at zero and above at the bound.
  always_comb begin
    if (sum < 0) begin
      pos_new = '0;
    end else if (sum > $signed({2'b00, lim})) begin
      pos_new = lim;
    end else begin
      pos_new = sum[POS_W-1:0];
    end
  end

endmodule
